// ===== src/igl_pkg.sv =====
`default_nettype none

package igl_pkg;

  // Operand width actually used; bit OPERAND_WIDTH-1 is the sign bit (8..32)
  localparam int unsigned OPERAND_WIDTH = 32;
  localparam int unsigned IN_WIDTH      = 32;
  localparam int unsigned RESULT_WIDTH  = 31;
  localparam int unsigned PROD_WIDTH    = 2 * OPERAND_WIDTH;
  localparam int unsigned CHECK_WIDTH   = 64;
  localparam int unsigned SHIFT_WIDTH   = $clog2(OPERAND_WIDTH);
  localparam int unsigned COUNT_WIDTH   = $clog2(OPERAND_WIDTH + 1);

  localparam logic [CHECK_WIDTH-1:0] INT_MAX = CHECK_WIDTH'(64'h7FFF_FFFF);

  // Operation codes
  localparam logic OP_GCD = 1'b0;
  localparam logic OP_LCM = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_GCD = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_UNUSED   = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic gcd_step;
    logic gcd_take;
    logic div_step;
    logic mul;
    logic finish;
  } igl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic gcd_end;
    logic div_last;
    logic lcm_path;
  } igl_stat_t;

  // Two's complement magnitude; the most negative value maps to 2^(W-1)
  function automatic logic [OPERAND_WIDTH-1:0] magnitude(
    input logic [OPERAND_WIDTH-1:0] v
  );
    logic [OPERAND_WIDTH-1:0] neg;
    neg = ~v + OPERAND_WIDTH'(1);
    return v[OPERAND_WIDTH-1] ? neg : v;
  endfunction

endpackage

`default_nettype wire

// ===== src/igl_datapath.sv =====
`default_nettype none

module igl_datapath import igl_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire igl_cmd_t                cmd_i,
  output igl_stat_t                    stat_o,
  input  wire logic                    operation_i,
  input  wire logic [IN_WIDTH-1:0]     first_operand_i,
  input  wire logic [IN_WIDTH-1:0]     second_operand_i,
  output logic [RESULT_WIDTH-1:0]      result_value_o,
  output logic [1:0]                   status_o,
  output logic                         done_o
);

  localparam int unsigned W = OPERAND_WIDTH;

  logic                      op_q;
  logic [W-1:0]              a_q, b_q;
  logic [W-1:0]              x_q, x_d, y_q, y_d;
  logic [SHIFT_WIDTH-1:0]    k_q, k_d;
  logic [W-1:0]              g_q;
  logic [W-1:0]              rem_q, quo_q;
  logic [COUNT_WIDTH-1:0]    cnt_q;
  logic [PROD_WIDTH-1:0]     prod_q;
  logic [RESULT_WIDTH-1:0]   res_q;
  logic [1:0]                st_q;
  logic                      done_q;

  logic [W-1:0]              gcd_val;
  logic [W:0]                trial;
  logic                      trial_ge;
  logic [W:0]                trial_sub;
  logic                      lcm_path;
  logic [CHECK_WIDTH-1:0]    val;
  logic [1:0]                st_d;
  logic [RESULT_WIDTH-1:0]   res_d;

  // Status back to the controller
  assign lcm_path        = (op_q == OP_LCM) && (a_q != '0) && (b_q != '0);
  assign stat_o.gcd_end  = (x_q == '0) || (y_q == '0);
  assign stat_o.div_last = (cnt_q == COUNT_WIDTH'(1));
  assign stat_o.lcm_path = lcm_path;

  // Binary gcd step: strip common twos, strip lone twos, subtract odd pair
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    k_d = k_q;
    if (!x_q[0] && !y_q[0]) begin
      x_d = x_q >> 1;
      y_d = y_q >> 1;
      k_d = k_q + SHIFT_WIDTH'(1);
    end else if (!x_q[0]) begin
      x_d = x_q >> 1;
    end else if (!y_q[0]) begin
      y_d = y_q >> 1;
    end else if (x_q >= y_q) begin
      x_d = x_q - y_q;
    end else begin
      y_d = y_q - x_q;
    end
  end

  assign gcd_val = (x_q | y_q) << k_q;

  // Restoring divider step, one quotient bit per cycle
  assign trial     = {rem_q, quo_q[W-1]};
  assign trial_ge  = trial >= {1'b0, g_q};
  assign trial_sub = trial - {1'b0, g_q};

  // Final value and status
  always_comb begin
    st_d = ST_OK;
    if (op_q == OP_GCD) begin
      val = CHECK_WIDTH'(g_q);
      if ((a_q == '0) && (b_q == '0)) st_d = ST_ZERO_GCD;
    end else begin
      val = lcm_path ? CHECK_WIDTH'(prod_q) : '0;
    end
    if ((st_d == ST_OK) && (val > INT_MAX)) st_d = ST_RANGE;
    res_d = (st_d == ST_OK) ? val[RESULT_WIDTH-1:0] : '0;
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= operation_i;
      a_q  <= magnitude(first_operand_i[W-1:0]);
      b_q  <= magnitude(second_operand_i[W-1:0]);
      x_q  <= magnitude(first_operand_i[W-1:0]);
      y_q  <= magnitude(second_operand_i[W-1:0]);
      k_q  <= '0;
    end
    if (cmd_i.gcd_step) begin
      x_q <= x_d;
      y_q <= y_d;
      k_q <= k_d;
    end
    if (cmd_i.gcd_take) begin
      g_q   <= gcd_val;
      rem_q <= '0;
      quo_q <= a_q;
      cnt_q <= COUNT_WIDTH'(W);
    end
    if (cmd_i.div_step) begin
      rem_q <= trial_ge ? trial_sub[W-1:0] : trial[W-1:0];
      quo_q <= {quo_q[W-2:0], trial_ge};
      cnt_q <= cnt_q - COUNT_WIDTH'(1);
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_WIDTH'(quo_q) * PROD_WIDTH'(b_q);
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
      st_q  <= st_d;
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  assign result_value_o = res_q;
  assign status_o       = st_q;
  assign done_o         = done_q;

endmodule

`default_nettype wire

// ===== src/igl_ctrl.sv =====
`default_nettype none

module igl_ctrl import igl_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  output logic           busy_o,
  output igl_cmd_t       cmd_o,
  input  wire igl_stat_t stat_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_GCD;
        end
      end
      S_GCD: begin
        if (stat_i.gcd_end) begin
          cmd_o.gcd_take = 1'b1;
          state_d        = stat_i.lcm_path ? S_DIV : S_FIN;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_FIN;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ===== src/integer_gcd_lcm_unit.sv =====
// Channel   Handshake           Payload
// command   start_i / busy_o    operation_i, first_operand_i, second_operand_i
// result    done_o (strobe)     result_value_o, status_o
//
// One word at a time. After the accept edge, the binary gcd runs (a shift or subtract each
// step) until an operand is zero, and then the gcd is latched; for lcm the divider follows,
// one quotient bit per step, and then one multiply step; then a finish step, after which
// busy_o returns low. The strobe follows finish, busy_o low.
// Reset clears the controller and the strobe; no results are pending after it.
// The receiver cannot stall: each result shows for exactly one cycle.
`default_nettype none

module integer_gcd_lcm_unit import igl_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic                operation_i,
  input  wire logic [IN_WIDTH-1:0] first_operand_i,
  input  wire logic [IN_WIDTH-1:0] second_operand_i,
  output logic                     done_o,
  output logic [RESULT_WIDTH-1:0]  result_value_o,
  output logic [1:0]               status_o
);

  igl_cmd_t  cmd;
  igl_stat_t stat;

  igl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd),
    .stat_i  (stat)
  );

  igl_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .operation_i      (operation_i),
    .first_operand_i  (first_operand_i),
    .second_operand_i (second_operand_i),
    .result_value_o   (result_value_o),
    .status_o         (status_o),
    .done_o           (done_o)
  );

  // A result only appears once the controller is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // An accepted word always keeps the unit busy the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("accepted word did not start work");

  // Failing status always carries a zero value, and code 3 is never sent
  a_status_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((status_o == ST_OK || result_value_o == '0) &&
                status_o != ST_UNUSED))
    else $error("bad status or value on result");

endmodule

`default_nettype wire
